// ===== sv/ctb_pkg.sv =====
// shared types and codes of the column texture blend unit
package ctb_pkg;

	localparam int MAP_AW = 8;

	localparam logic [2:0] MODE_LOAD_TEXEL = 3'd0;
	localparam logic [2:0] MODE_LOAD_COLOR = 3'd1;
	localparam logic [2:0] MODE_LOAD_TRANS = 3'd2;
	localparam logic [2:0] MODE_START      = 3'd3;
	localparam logic [2:0] MODE_PIXEL      = 3'd4;

	localparam logic [2:0] DRAW_OPAQUE     = 3'd0;
	localparam logic [2:0] DRAW_TRANSLATED = 3'd1;
	localparam logic [2:0] DRAW_BLEND75    = 3'd2;
	localparam logic [2:0] DRAW_BLEND50    = 3'd3;
	localparam logic [2:0] DRAW_BLEND25    = 3'd4;

	localparam logic [1:0] REG_VIEW_CENTER  = 2'd0;
	localparam logic [1:0] REG_HALF_MASK    = 2'd1;
	localparam logic [1:0] REG_QUARTER_MASK = 2'd2;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_TEXEL = 2'd1,
		OP_COLOR = 2'd2,
		OP_TRANS = 2'd3
	} op_t;

	typedef struct packed {
		logic [2:0]  draw_mode;
		logic [9:0]  row;
		logic [15:0] dest;
	} pix_info_t;

	typedef struct packed {
		logic       pix_go;
		logic [2:0] draw_mode;
		logic [9:0] row;
	} col_t;

	typedef struct packed {
		logic        go;
		op_t         op;
		logic [7:0]  index;
		logic [15:0] value;
		pix_info_t   pix;
	} issue_t;

endpackage

// ===== sv/column_texture_blend_unit.sv =====
// Column texture blend unit: takes one item per cycle while in_stall is low (loads, column
// starts and pixels alike). A pixel's texel is read at the edge that accepts its beat,
// and the translation map read, the color map read and the blend output register
// follow in that order, though a stalled output can hold them back. Three internal stages
// buffer items, so input beats keep being taken while a result waits on a stalled
// output until they fill.
// The tables have no reset and need no clearing pass; reading an unwritten entry
// gives undefined pixel data. TEX_DEPTH must be a power of two.
module column_texture_blend_unit import ctb_pkg::*; #(
	parameter int TEX_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [7:0]         table_index,
	input  logic [15:0]        table_value,
	input  logic [9:0]         start_row,
	input  logic [9:0]         end_row,
	input  logic signed [31:0] texture_mid,
	input  logic signed [31:0] tex_step,
	input  logic [2:0]         draw_mode,
	input  logic [15:0]        dest_pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        pixel_out,
	output logic [9:0]         row,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int TEX_AW = $clog2(TEX_DEPTH);

	logic [9:0]  view_center_q;
	logic [15:0] half_mask_q;
	logic [15:0] quarter_mask_q;

	logic              ready;
	logic              acc;
	col_t              col;
	logic [TEX_AW-1:0] tex_idx;
	issue_t            issue;
	logic              rdy_out;
	logic              v_s3;
	pix_info_t         pix_s3;
	logic [15:0]       color_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_center_q  <= 10'd100;
			half_mask_q    <= 16'd31727;
			quarter_mask_q <= 16'd14823;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VIEW_CENTER:  view_center_q  <= cfg_data[9:0];
				REG_HALF_MASK:    half_mask_q    <= cfg_data;
				REG_QUARTER_MASK: quarter_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !ready;
	assign acc      = in_valid && ready;

	ctb_coord #(
		.TEX_AW (TEX_AW)
	) u_coord (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc             (acc),
		.mode            (mode),
		.start_row       (start_row),
		.end_row         (end_row),
		.texture_mid     (texture_mid),
		.tex_step        (tex_step),
		.draw_mode       (draw_mode),
		.view_center_row (view_center_q),
		.col             (col),
		.tex_idx         (tex_idx)
	);

	// only loads and pixels of an active column enter the table pipeline
	always_comb begin
		issue.index          = table_index;
		issue.value          = table_value;
		issue.pix.draw_mode  = col.draw_mode;
		issue.pix.row        = col.row;
		issue.pix.dest       = dest_pixel;
		case (mode)
			MODE_LOAD_TEXEL: begin
				issue.go = acc;
				issue.op = OP_TEXEL;
			end
			MODE_LOAD_COLOR: begin
				issue.go = acc;
				issue.op = OP_COLOR;
			end
			MODE_LOAD_TRANS: begin
				issue.go = acc;
				issue.op = OP_TRANS;
			end
			MODE_PIXEL: begin
				issue.go = acc && col.pix_go;
				issue.op = OP_PIXEL;
			end
			default: begin
				issue.go = 1'b0;
				issue.op = OP_PIXEL;
			end
		endcase
	end

	ctb_lookup #(
		.TEX_DEPTH (TEX_DEPTH),
		.TEX_AW    (TEX_AW)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.tex_idx  (tex_idx),
		.rdy_out  (rdy_out),
		.ready    (ready),
		.v_s3     (v_s3),
		.pix_s3   (pix_s3),
		.color_s3 (color_s3)
	);

	ctb_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s3         (v_s3),
		.pix_s3       (pix_s3),
		.color_s3     (color_s3),
		.half_mask    (half_mask_q),
		.quarter_mask (quarter_mask_q),
		.out_stall    (out_stall),
		.rdy_out      (rdy_out),
		.out_valid    (out_valid),
		.pixel_out    (pixel_out),
		.row          (row)
	);

endmodule

// ===== sv/ctb_coord.sv =====
// column state: row range, draw mode and the 16.16 texture coordinate
module ctb_coord import ctb_pkg::*; #(
	parameter int TEX_AW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [2:0]          mode,
	input  logic [9:0]          start_row,
	input  logic [9:0]          end_row,
	input  logic signed [31:0]  texture_mid,
	input  logic signed [31:0]  tex_step,
	input  logic [2:0]          draw_mode,
	input  logic [9:0]          view_center_row,
	output col_t                col,
	output logic [TEX_AW-1:0]   tex_idx
);

	logic [31:0] tex_coord_q;
	logic [31:0] coord_step_q;
	logic [2:0]  cur_mode_q;
	logic [9:0]  cur_row_q;
	logic [9:0]  last_row_q;
	logic        active_q;

	logic signed [10:0] diff;
	logic [31:0]        diff32;
	logic [31:0]        prod;
	logic [31:0]        start_coord;

	assign diff        = $signed({1'b0, start_row}) - $signed({1'b0, view_center_row});
	assign diff32      = 32'(diff);
	// only the low 32 bits of the product matter
	assign prod        = diff32 * $unsigned(tex_step);
	assign start_coord = $unsigned(texture_mid) + prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_coord_q  <= '0;
			coord_step_q <= '0;
			cur_mode_q   <= '0;
			cur_row_q    <= '0;
			last_row_q   <= '0;
			active_q     <= 1'b0;
		end else if (acc) begin
			case (mode)
				MODE_START: begin
					coord_step_q <= $unsigned(tex_step);
					tex_coord_q  <= start_coord;
					cur_mode_q   <= draw_mode;
					cur_row_q    <= start_row;
					last_row_q   <= end_row;
					active_q     <= (end_row >= start_row);
				end
				MODE_PIXEL: begin
					if (active_q) begin
						if (cur_row_q >= last_row_q) begin
							active_q <= 1'b0;
						end else begin
							cur_row_q   <= cur_row_q + 10'd1;
							tex_coord_q <= tex_coord_q + coord_step_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign col.pix_go    = active_q && (mode == MODE_PIXEL);
	assign col.draw_mode = cur_mode_q;
	assign col.row       = cur_row_q;
	assign tex_idx       = tex_coord_q[16 +: TEX_AW];

endmodule

// ===== sv/ctb_lookup.sv =====
// three chained table memories: texel, translation, color map
module ctb_lookup import ctb_pkg::*; #(
	parameter int TEX_DEPTH = 128,
	parameter int TEX_AW    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  issue_t            issue,
	input  logic [TEX_AW-1:0] tex_idx,
	input  logic              rdy_out,
	output logic              ready,
	output logic              v_s3,
	output pix_info_t         pix_s3,
	output logic [15:0]       color_s3
);

	localparam int MAP_DEPTH = 1 << MAP_AW;

	logic [7:0]  texel_mem [TEX_DEPTH];
	logic [7:0]  trans_mem [MAP_DEPTH];
	logic [15:0] color_mem [MAP_DEPTH];

	logic        v_s1, v_s2;
	op_t         op_s1, op_s2;
	logic [7:0]  idx_s1, idx_s2;
	logic [15:0] val_s1, val_s2;
	pix_info_t   pix_s1, pix_s2;
	logic [7:0]  texel_s1, texel_s2;
	logic [7:0]  trans_s2;

	logic        rdy1, rdy2, rdy3;
	logic [7:0]  caddr;

	// loads ride the same stages as pixels, so each memory sees its accesses in order
	assign rdy3  = !v_s3 || rdy_out;
	assign rdy2  = !v_s2 || rdy3;
	assign rdy1  = !v_s1 || rdy2;
	assign ready = rdy1;

	assign caddr = (pix_s2.draw_mode == DRAW_TRANSLATED) ? trans_s2 : texel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= issue.go;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2 && (op_s2 == OP_PIXEL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue.go) begin
			op_s1  <= issue.op;
			idx_s1 <= issue.index;
			val_s1 <= issue.value;
			pix_s1 <= issue.pix;
		end
		if (issue.go && issue.op == OP_TEXEL) begin
			texel_mem[TEX_AW'(issue.index)] <= issue.value[7:0];
		end
		if (issue.go && issue.op == OP_PIXEL) begin
			texel_s1 <= texel_mem[tex_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2    <= op_s1;
			idx_s2   <= idx_s1;
			val_s2   <= val_s1;
			pix_s2   <= pix_s1;
			texel_s2 <= texel_s1;
		end
		if (rdy2 && v_s1 && op_s1 == OP_TRANS) begin
			trans_mem[idx_s1] <= val_s1[7:0];
		end
		if (rdy2 && v_s1 && op_s1 == OP_PIXEL) begin
			trans_s2 <= trans_mem[texel_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2 && op_s2 == OP_PIXEL) begin
			pix_s3   <= pix_s2;
			color_s3 <= color_mem[caddr];
		end
		if (rdy3 && v_s2 && op_s2 == OP_COLOR) begin
			color_mem[idx_s2] <= val_s2;
		end
	end

endmodule

// ===== sv/ctb_blend.sv =====
// pixel blend and output register
module ctb_blend import ctb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_s3,
	input  pix_info_t   pix_s3,
	input  logic [15:0] color_s3,
	input  logic [15:0] half_mask,
	input  logic [15:0] quarter_mask,
	input  logic        out_stall,
	output logic        rdy_out,
	output logic        out_valid,
	output logic [15:0] pixel_out,
	output logic [9:0]  row
);

	logic        out_valid_q;
	logic [15:0] pixel_q;
	logic [9:0]  row_q;
	logic [15:0] src, dst;
	logic [15:0] h_src, q_src, h_dst, q_dst;
	logic [15:0] blend;

	assign src   = color_s3;
	assign dst   = pix_s3.dest;
	assign h_src = (src >> 1) & half_mask;
	assign q_src = (src >> 2) & quarter_mask;
	assign h_dst = (dst >> 1) & half_mask;
	assign q_dst = (dst >> 2) & quarter_mask;

	always_comb begin
		case (pix_s3.draw_mode)
			DRAW_BLEND75: blend = q_dst + h_src + q_src;
			DRAW_BLEND50: blend = h_dst + h_src;
			DRAW_BLEND25: blend = h_dst + q_dst + q_src;
			// translated pixels already come from the remapped color entry
			default:      blend = src;
		endcase
	end

	assign rdy_out = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			pixel_q <= blend;
			row_q   <= pix_s3.row;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign row       = row_q;

endmodule

// ===== sv/ctb_checker.sv =====
// port-level checks for the column texture blend unit, with its bind
module ctb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] pixel_out,
	input logic [9:0]  row
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(row))
		else $error("stalled output beat changed");

	// input back-pressure only comes from a full pipe behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a result beat only goes away once taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output beat dropped while stalled");

	// nothing leaves the block straight out of reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid out of reset");

endmodule

bind column_texture_blend_unit ctb_checker u_ctb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_out (pixel_out),
	.row       (row)
);
